// ===== rtl/ukvt_pkg.sv =====
// ----------------------------------------------------------------------------
// Key-value table package
// Request kinds, result codes and sequencer states of the key-value table.
// ----------------------------------------------------------------------------
package ukvt_pkg;

  typedef enum logic [1:0] {
    OP_PUT = 2'd0,
    OP_GET = 2'd1,
    OP_DEL = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_DELETED   = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_e;

endpackage

// ===== rtl/ukvt_store.sv =====
// ----------------------------------------------------------------------------
// Key-value table storage
// Key and value memories with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ukvt_store #(
  parameter int CAPACITY   = 16,
  parameter int KEY_BITS   = 16,
  parameter int VALUE_BITS = 32,
  parameter int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  logic [IDX_W-1:0]      wr_addr_i,
  input  logic [KEY_BITS-1:0]   wr_key_i,
  input  logic [VALUE_BITS-1:0] wr_value_i,
  input  logic                  rd_en_i,
  input  logic [IDX_W-1:0]      rd_addr_i,
  output logic [KEY_BITS-1:0]   rd_key_o,
  output logic [VALUE_BITS-1:0] rd_value_o
);

  logic [KEY_BITS-1:0]   key_mem [CAPACITY];
  logic [VALUE_BITS-1:0] val_mem [CAPACITY];
  logic [KEY_BITS-1:0]   rd_key_q;
  logic [VALUE_BITS-1:0] rd_value_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_mem[wr_addr_i] <= wr_key_i;
      val_mem[wr_addr_i] <= wr_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_key_q   <= key_mem[rd_addr_i];
      rd_value_q <= val_mem[rd_addr_i];
    end
  end

  assign rd_key_o   = rd_key_q;
  assign rd_value_o = rd_value_q;

endmodule

// ===== rtl/ukvt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Key-value table sequencer
// Scans the live entries through one key comparator, then updates, appends
// or compacts the table and hands one result to the output stage.
// ----------------------------------------------------------------------------
module ukvt_ctrl #(
  parameter int CAPACITY   = 16,
  parameter int KEY_BITS   = 16,
  parameter int VALUE_BITS = 32,
  parameter int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ukvt_pkg::op_e         in_op_i,
  input  logic [KEY_BITS-1:0]   in_key_i,
  input  logic [VALUE_BITS-1:0] in_value_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output ukvt_pkg::status_e     res_status_o,
  output logic [VALUE_BITS-1:0] res_value_o,
  output logic                  wr_en_o,
  output logic [IDX_W-1:0]      wr_addr_o,
  output logic [KEY_BITS-1:0]   wr_key_o,
  output logic [VALUE_BITS-1:0] wr_value_o,
  output logic                  rd_en_o,
  output logic [IDX_W-1:0]      rd_addr_o,
  input  logic [KEY_BITS-1:0]   rd_key_i,
  input  logic [VALUE_BITS-1:0] rd_value_i
);

  ukvt_pkg::state_e  state_q, state_d;
  ukvt_pkg::op_e     op_q, op_d;
  ukvt_pkg::status_e status_q, status_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [VALUE_BITS-1:0] vout_q, vout_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      scan_q, scan_d;
  logic                  pend_q, pend_d;
  logic [IDX_W-1:0]      pidx_q, pidx_d;
  logic [IDX_W-1:0]      dst_q, dst_d;
  logic                  hit;
  logic                  more;

  // The single key comparator and the index bound check.
  assign hit  = pend_q && (rd_key_i == key_q);
  assign more = scan_q < count_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ukvt_pkg::S_IDLE: begin
        if (in_valid_i) state_d = ukvt_pkg::S_SCAN;
      end
      ukvt_pkg::S_SCAN: begin
        if (hit && op_q == ukvt_pkg::OP_DEL) state_d = ukvt_pkg::S_SHIFT;
        else if (hit || !more) state_d = ukvt_pkg::S_DONE;
      end
      ukvt_pkg::S_SHIFT: begin
        if (!pend_q && !more) state_d = ukvt_pkg::S_DONE;
      end
      ukvt_pkg::S_DONE: begin
        if (res_ready_i) state_d = ukvt_pkg::S_IDLE;
      end
      default: state_d = ukvt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op_d       = op_q;
    key_d      = key_q;
    val_d      = val_q;
    vout_d     = vout_q;
    status_d   = status_q;
    count_d    = count_q;
    scan_d     = scan_q;
    pend_d     = pend_q;
    pidx_d     = pidx_q;
    dst_d      = dst_q;
    in_ready_o = 1'b0;
    res_valid_o = 1'b0;
    wr_en_o    = 1'b0;
    wr_addr_o  = pidx_q;
    wr_key_o   = key_q;
    wr_value_o = val_q;
    rd_en_o    = 1'b0;
    rd_addr_o  = scan_q[IDX_W-1:0];
    case (state_q)
      ukvt_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d     = in_op_i;
          key_d    = in_key_i;
          val_d    = in_value_i;
          vout_d   = '0;
          status_d = ukvt_pkg::ST_NOT_FOUND;
          scan_d   = '0;
          pend_d   = 1'b0;
        end
      end
      ukvt_pkg::S_SCAN: begin
        pend_d = 1'b0;
        if (hit) begin
          case (op_q)
            ukvt_pkg::OP_PUT: begin
              wr_en_o  = 1'b1;
              status_d = ukvt_pkg::ST_UPDATED;
            end
            ukvt_pkg::OP_GET: begin
              vout_d   = rd_value_i;
              status_d = ukvt_pkg::ST_FOUND;
            end
            ukvt_pkg::OP_DEL: begin
              dst_d    = pidx_q;
              scan_d   = CNT_W'(pidx_q) + CNT_W'(1);
              status_d = ukvt_pkg::ST_DELETED;
            end
            default: status_d = ukvt_pkg::ST_NOT_FOUND;
          endcase
        end else if (more) begin
          rd_en_o = 1'b1;
          pend_d  = 1'b1;
          pidx_d  = scan_q[IDX_W-1:0];
          scan_d  = scan_q + CNT_W'(1);
        end else if (op_q == ukvt_pkg::OP_PUT) begin
          if (count_q == CNT_W'(CAPACITY)) begin
            status_d = ukvt_pkg::ST_FULL;
          end else begin
            wr_en_o   = 1'b1;
            wr_addr_o = count_q[IDX_W-1:0];
            count_d   = count_q + CNT_W'(1);
            status_d  = ukvt_pkg::ST_INSERTED;
          end
        end
      end
      ukvt_pkg::S_SHIFT: begin
        pend_d = more;
        if (pend_q) begin
          wr_en_o    = 1'b1;
          wr_addr_o  = dst_q;
          wr_key_o   = rd_key_i;
          wr_value_o = rd_value_i;
          dst_d      = dst_q + IDX_W'(1);
        end
        if (more) begin
          rd_en_o = 1'b1;
          scan_d  = scan_q + CNT_W'(1);
        end
        if (!pend_q && !more) count_d = count_q - CNT_W'(1);
      end
      ukvt_pkg::S_DONE: begin
        res_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ukvt_pkg::S_IDLE;
      count_q <= '0;
      scan_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      scan_q  <= scan_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    val_q    <= val_d;
    vout_q   <= vout_d;
    status_q <= status_d;
    pidx_q   <= pidx_d;
    dst_q    <= dst_d;
  end

  assign res_status_o = status_q;
  assign res_value_o  = vout_q;

endmodule

// ===== rtl/unordered_key_value_table.sv =====
// ----------------------------------------------------------------------------
// Unordered key-value table
// Put, get and delete requests on a packed table searched linearly.
// ----------------------------------------------------------------------------
// One request is handled at a time. A put or get reads one entry from the key
// memory and compares it each cycle, so its time from accept to result grows
// with the number of live entries. A delete that hits also moves every later
// entry down one slot through the same read and write port.
// The result sits in an output register, so a new request is accepted while
// the previous result still waits on the master side.
module unordered_key_value_table #(
  parameter int CAPACITY   = 16,
  parameter int KEY_BITS   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // Fields from bit 0: key, value, zero fill to whole bytes.
  input  logic [((KEY_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // Fields from bit 0: operation.
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // Fields from bit 0: value_out, zero fill to whole bytes.
  output logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // Fields from bit 0: status.
  output logic [2:0]          m_axis_tuser
);

  localparam int OUT_W = ((VALUE_BITS + 7) / 8) * 8;
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                  res_valid;
  logic                  res_ready;
  ukvt_pkg::status_e     res_status;
  logic [VALUE_BITS-1:0] res_value;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [KEY_BITS-1:0]   wr_key;
  logic [VALUE_BITS-1:0] wr_value;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_value;

  logic                  m_valid_q, m_valid_d;
  ukvt_pkg::status_e     m_status_q;
  logic [VALUE_BITS-1:0] m_value_q;

  ukvt_ctrl #(
    .CAPACITY  (CAPACITY),
    .KEY_BITS  (KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (ukvt_pkg::op_e'(s_axis_tuser)),
    .in_key_i    (s_axis_tdata[KEY_BITS-1:0]),
    .in_value_i  (s_axis_tdata[KEY_BITS +: VALUE_BITS]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_status_o(res_status),
    .res_value_o (res_value),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_key_o    (wr_key),
    .wr_value_o  (wr_value),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_key_i    (rd_key),
    .rd_value_i  (rd_value)
  );

  ukvt_store #(
    .CAPACITY  (CAPACITY),
    .KEY_BITS  (KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_key_i  (wr_key),
    .wr_value_i(wr_value),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_key_o  (rd_key),
    .rd_value_o(rd_value)
  );

  assign res_ready = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    if (res_valid && res_ready) m_valid_d = 1'b1;
    else if (m_axis_tready) m_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      m_status_q <= res_status;
      m_value_q  <= res_value;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_W'(m_value_q);
  assign m_axis_tuser  = m_status_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while the previous one is in progress");

  a_no_accept_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !s_axis_tready)
    else $error("input ready while a result is pending in the sequencer");

  a_value_only_on_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != ukvt_pkg::ST_FOUND) |-> (m_axis_tdata == '0))
    else $error("nonzero value returned without a successful lookup");

endmodule

// ===== tb/unordered_key_value_table_test.sv =====
// ----------------------------------------------------------------------------
// Unordered key-value table testbench
// Sends put, get and delete requests, including the unused request code,
// and checks every result beat against a behavioral copy of the table or,
// for typed directed rows, the result in the row. A short directed table
// covers the empty and full table, updates, hits and misses, and deletes
// at the front, middle and end. Random requests on a small pool of keys
// follow, under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module unordered_key_value_table_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 16;
  localparam int KEY_POOL_SIZE = 24;
  localparam int RANDOM_PER_PHASE = 104;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    ukvt_pkg::status_e status;
    logic [31:0]       value_out;
  } table_result_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [15:0]       key;
    logic [31:0]       value;
    int                count;
    bit                typed;
    ukvt_pkg::status_e status;
    logic [31:0]       value_out;
  } request_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  logic [15:0] mirror_keys [TABLE_DEPTH];
  logic [31:0] mirror_values [TABLE_DEPTH];
  int          mirror_count;

  table_result_t pending_results[$];
  int            error_count = 0;
  int            send_idle_pct;
  int            recv_stall_pct;

  request_row_t directed_rows [23] = '{
    '{ukvt_pkg::OP_GET, 16'h0000, 32'hFFFF_FFFF, 1,  1'b1, ukvt_pkg::ST_NOT_FOUND, 32'h0},
    '{ukvt_pkg::OP_DEL, 16'hFFFF, 32'h0000_0000, 1,  1'b1, ukvt_pkg::ST_NOT_FOUND, 32'h0},
    '{OP_UNUSED,        16'h1234, 32'hDEAD_BEEF, 1,  1'b1, ukvt_pkg::ST_NOT_FOUND, 32'h0},
    '{ukvt_pkg::OP_PUT, 16'hFFFF, 32'hFFFF_FFFF, 1,  1'b1, ukvt_pkg::ST_INSERTED,  32'h0},
    '{ukvt_pkg::OP_GET, 16'hFFFF, 32'h0000_0000, 1,  1'b1, ukvt_pkg::ST_FOUND,
      32'hFFFF_FFFF},
    '{ukvt_pkg::OP_PUT, 16'h0000, 32'h0000_0000, 1,  1'b1, ukvt_pkg::ST_INSERTED,  32'h0},
    '{ukvt_pkg::OP_GET, 16'h0000, 32'h0000_0000, 1,  1'b1, ukvt_pkg::ST_FOUND,     32'h0},
    '{ukvt_pkg::OP_PUT, 16'hFFFF, 32'h0000_0000, 1,  1'b1, ukvt_pkg::ST_UPDATED,   32'h0},
    '{ukvt_pkg::OP_GET, 16'hFFFF, 32'hFFFF_FFFF, 1,  1'b1, ukvt_pkg::ST_FOUND,     32'h0},
    '{ukvt_pkg::OP_PUT, 16'h0100, 32'hA5A5_0000, 14, 1'b0, ukvt_pkg::ST_NOT_FOUND, 32'h0},
    '{ukvt_pkg::OP_PUT, 16'h8000, 32'h1234_5678, 1,  1'b1, ukvt_pkg::ST_FULL,      32'h0},
    '{ukvt_pkg::OP_PUT, 16'h0000, 32'h8000_0001, 1,  1'b1, ukvt_pkg::ST_UPDATED,   32'h0},
    '{ukvt_pkg::OP_GET, 16'h010D, 32'h0000_0000, 1,  1'b0, ukvt_pkg::ST_NOT_FOUND, 32'h0},
    '{OP_UNUSED,        16'hFFFF, 32'hFFFF_FFFF, 1,  1'b1, ukvt_pkg::ST_NOT_FOUND, 32'h0},
    '{ukvt_pkg::OP_DEL, 16'hFFFF, 32'h0000_0000, 1,  1'b1, ukvt_pkg::ST_DELETED,   32'h0},
    '{ukvt_pkg::OP_GET, 16'h010D, 32'h0000_0000, 1,  1'b0, ukvt_pkg::ST_NOT_FOUND, 32'h0},
    '{ukvt_pkg::OP_DEL, 16'h0106, 32'h0000_0000, 1,  1'b1, ukvt_pkg::ST_DELETED,   32'h0},
    '{ukvt_pkg::OP_DEL, 16'h0106, 32'h0000_0000, 1,  1'b1, ukvt_pkg::ST_NOT_FOUND, 32'h0},
    '{ukvt_pkg::OP_DEL, 16'h010D, 32'h0000_0000, 1,  1'b1, ukvt_pkg::ST_DELETED,   32'h0},
    '{ukvt_pkg::OP_PUT, 16'h8000, 32'h5A5A_5A5A, 1,  1'b1, ukvt_pkg::ST_INSERTED,  32'h0},
    '{ukvt_pkg::OP_GET, 16'h8000, 32'h0000_0000, 1,  1'b1, ukvt_pkg::ST_FOUND,
      32'h5A5A_5A5A},
    '{ukvt_pkg::OP_GET, 16'h0105, 32'h0000_0000, 1,  1'b0, ukvt_pkg::ST_NOT_FOUND, 32'h0},
    '{ukvt_pkg::OP_DEL, 16'h0000, 32'h0000_0000, 1,  1'b1, ukvt_pkg::ST_DELETED,   32'h0}
  };

  unordered_key_value_table #(
    .CAPACITY  (TABLE_DEPTH),
    .KEY_BITS  (16),
    .VALUE_BITS(32)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic table_result_t apply_request(input logic [1:0] op,
                                                  input logic [15:0] key,
                                                  input logic [31:0] value);
    table_result_t res;
    int slot;
    res.status = ukvt_pkg::ST_NOT_FOUND;
    res.value_out = '0;
    slot = 0;
    while (slot < mirror_count && mirror_keys[slot] != key) slot++;
    case (op)
      ukvt_pkg::OP_PUT: begin
        if (slot < mirror_count) begin
          mirror_values[slot] = value;
          res.status = ukvt_pkg::ST_UPDATED;
        end else if (mirror_count >= TABLE_DEPTH) begin
          res.status = ukvt_pkg::ST_FULL;
        end else begin
          mirror_keys[mirror_count] = key;
          mirror_values[mirror_count] = value;
          mirror_count++;
          res.status = ukvt_pkg::ST_INSERTED;
        end
      end
      ukvt_pkg::OP_GET: begin
        if (slot < mirror_count) begin
          res.value_out = mirror_values[slot];
          res.status = ukvt_pkg::ST_FOUND;
        end
      end
      ukvt_pkg::OP_DEL: begin
        if (slot < mirror_count) begin
          mirror_count--;
          for (int s = slot; s < mirror_count; s++) begin
            mirror_keys[s] = mirror_keys[s + 1];
            mirror_values[s] = mirror_values[s + 1];
          end
          res.status = ukvt_pkg::ST_DELETED;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic issue_request(input logic [1:0] op, input logic [15:0] key,
                               input logic [31:0] value, input bit typed,
                               input table_result_t typed_result);
    table_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {value, key};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = apply_request(op, key, value);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with nothing expected: status %0d value %h",
                   $time, m_axis_tuser, m_axis_tdata);
          error_count++;
        end else begin
          if (m_axis_tuser !== pending_results[0].status) begin
            $display("%0t: status mismatch: expected %0d actual %0d", $time,
                     pending_results[0].status, m_axis_tuser);
            error_count++;
          end
          if (m_axis_tdata !== pending_results[0].value_out) begin
            $display("%0t: value_out mismatch: expected %h actual %h", $time,
                     pending_results[0].value_out, m_axis_tdata);
            error_count++;
          end
          void'(pending_results.pop_front());
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #2ms;
    $display("unordered_key_value_table_test failed");
    $finish;
  end

  initial begin
    logic [15:0] key_pool [KEY_POOL_SIZE];
    logic [1:0]  op;
    logic [15:0] key;
    logic [31:0] value;
    table_result_t typed_result;
    int roll;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    m_axis_tready <= 1'b0;
    rst_ni        <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mirror_count   = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      typed_result.status = directed_rows[r].status;
      typed_result.value_out = directed_rows[r].value_out;
      for (int j = 0; j < directed_rows[r].count; j++) begin
        issue_request(directed_rows[r].op, directed_rows[r].key + 16'(j),
                      directed_rows[r].value + j, directed_rows[r].typed, typed_result);
      end
    end
    wait_for_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      foreach (key_pool[p]) key_pool[p] = 16'($urandom_range(16'hFFFF));
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        roll = $urandom_range(99);
        if (roll < 45) op = ukvt_pkg::OP_PUT;
        else if (roll < 75) op = ukvt_pkg::OP_GET;
        else if (roll < 95) op = ukvt_pkg::OP_DEL;
        else op = OP_UNUSED;
        if ($urandom_range(99) < 90) key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
        else key = 16'($urandom_range(16'hFFFF));
        value = $urandom;
        issue_request(op, key, value, 1'b0, typed_result);
      end
      wait_for_results();
    end

    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("unordered_key_value_table_test passed");
    end else begin
      $display("unordered_key_value_table_test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ukvt_pkg.sv
rtl/ukvt_store.sv
rtl/ukvt_ctrl.sv
rtl/unordered_key_value_table.sv
tb/unordered_key_value_table_test.sv
